// ----- src/hfbs_pkg.sv -----
package hfbs_pkg;

	localparam logic [1:0] FUNC_FLAG = 2'd0;
	localparam logic [1:0] FUNC_DATA = 2'd1;
	localparam logic [1:0] FUNC_EOF  = 2'd2;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [15:0] CRC_POLY  = 16'h8408;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [2:0]  STUFF_RUN = 3'd5;
	localparam logic [2:0]  ONES_MAX  = 3'd7;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic line_bit;
		logic last_bit;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_FLAG,
		CMD_DATA,
		CMD_EOF
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} q_head_t;

endpackage

// ----- src/hdlc_frame_bit_serializer_core.sv -----
// HDLC frame serializer: each item (flag, payload byte or end of frame) becomes line bits,
// LSB first, one bit per cycle on the result channel while it is not stalled. A flag gives
// 8 line bits, a payload byte 8 to 10 bits depending on inserted zeros, and an end of frame
// 24 to 28 bits (inverted CRC low and high byte, then the closing flag). The bit serializer
// produces one line bit per cycle into the output register unless the result channel
// stalls. Items wait in a two-entry command queue, so new items are taken while bits are
// still being sent; an unused function code is dropped without results. The CRC is taken
// when the end of frame item reaches the serializer, after all earlier bytes have been sent.
module hdlc_frame_bit_serializer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  hfbs_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output hfbs_pkg::out_item_t result
);

	hfbs_pkg::q_head_t head;
	logic              pop;

	hfbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.head       (head),
		.pop        (pop)
	);

	hfbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- src/hfbs_front.sv -----
module hfbs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  hfbs_pkg::in_item_t item,
	output hfbs_pkg::q_head_t  head,
	input  logic               pop
);

	hfbs_pkg::cmd_t                  mem_q [hfbs_pkg::QDEPTH];
	logic [hfbs_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [hfbs_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [hfbs_pkg::QCNT_W-1:0]     cnt_q;
	hfbs_pkg::cmd_t                  cls;
	logic                            cls_ok;
	logic                            push;
	logic                            do_pop;

	always_comb begin
		cls.data = item.data_byte;
		cls_ok   = 1'b1;
		case (item.func)
			hfbs_pkg::FUNC_FLAG: cls.kind = hfbs_pkg::CMD_FLAG;
			hfbs_pkg::FUNC_DATA: cls.kind = hfbs_pkg::CMD_DATA;
			hfbs_pkg::FUNC_EOF:  cls.kind = hfbs_pkg::CMD_EOF;
			default: begin
				cls.kind = hfbs_pkg::CMD_FLAG;
				cls_ok   = 1'b0;
			end
		endcase
	end

	assign item_stall = (cnt_q == hfbs_pkg::QCNT_W'(hfbs_pkg::QDEPTH));
	assign push       = item_valid && !item_stall && cls_ok;
	assign do_pop     = pop && (cnt_q != '0);

	assign head.vld = (cnt_q != '0);
	assign head.cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == hfbs_pkg::QPTR_W'(hfbs_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == hfbs_pkg::QPTR_W'(hfbs_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/hfbs_back.sv -----
module hfbs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hfbs_pkg::q_head_t   head,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output hfbs_pkg::out_item_t result
);

	typedef enum logic [1:0] {
		SEG_DATA,
		SEG_FCS_LO,
		SEG_FCS_HI,
		SEG_FLAG
	} seg_t;

	logic        busy_q;
	logic [7:0]  sh_q;
	logic [2:0]  cnt_q;
	logic        stf_q;
	logic        pend_q;
	logic        fin_q;
	seg_t        seg_q;
	logic [7:0]  hi_q;
	logic [15:0] crc_q;
	logic [2:0]  ones_q;
	logic        res_vld_q;
	hfbs_pkg::out_item_t res_q;

	logic [15:0] fcs;
	logic [7:0]  c_sh;
	logic [2:0]  c_cnt;
	logic        c_stf;
	logic        c_pend;
	logic        c_fin;
	seg_t        c_seg;
	logic [7:0]  c_hi;
	logic        c_vld;
	logic        can_load;
	logic        go;

	logic [7:0]  n_sh;
	logic [2:0]  n_cnt;
	logic        n_stf;
	logic        n_pend;
	logic        n_fin;
	seg_t        n_seg;
	logic        n_busy;
	logic [15:0] n_crc;
	logic [2:0]  n_ones;
	logic [2:0]  ones_inc;
	logic        bit_o;
	logic        last_o;
	logic        stuff;
	logic        seg_end;

	assign fcs = crc_q ^ hfbs_pkg::CRC_INIT;

	always_comb begin
		if (busy_q) begin
			c_sh   = sh_q;
			c_cnt  = cnt_q;
			c_stf  = stf_q;
			c_pend = pend_q;
			c_fin  = fin_q;
			c_seg  = seg_q;
			c_hi   = hi_q;
		end else begin
			c_cnt  = 3'd7;
			c_pend = 1'b0;
			c_fin  = 1'b0;
			c_hi   = fcs[15:8];
			case (head.cmd.kind)
				hfbs_pkg::CMD_DATA: begin
					c_sh  = head.cmd.data;
					c_stf = 1'b1;
					c_seg = SEG_DATA;
				end
				hfbs_pkg::CMD_EOF: begin
					c_sh  = fcs[7:0];
					c_stf = 1'b1;
					c_seg = SEG_FCS_LO;
				end
				default: begin
					c_sh  = hfbs_pkg::FLAG_BYTE;
					c_stf = 1'b0;
					c_seg = SEG_FLAG;
				end
			endcase
		end
	end

	assign c_vld    = busy_q || head.vld;
	assign can_load = !res_vld_q || !result_stall;
	assign go       = c_vld && can_load;
	assign pop      = go && !busy_q;

	always_comb begin
		n_sh     = c_sh >> 1;
		n_cnt    = c_cnt - 3'd1;
		n_stf    = c_stf;
		n_pend   = 1'b0;
		n_fin    = 1'b0;
		n_seg    = c_seg;
		n_busy   = 1'b1;
		n_crc    = crc_q;
		n_ones   = ones_q;
		ones_inc = (ones_q < hfbs_pkg::ONES_MAX) ? ones_q + 3'd1 : ones_q;
		bit_o    = 1'b0;
		last_o   = 1'b0;
		stuff    = 1'b0;
		seg_end  = 1'b0;

		if (c_pend) begin
			n_sh    = c_sh;
			n_cnt   = c_cnt;
			n_ones  = '0;
			seg_end = c_fin;
		end else begin
			bit_o = c_sh[0];
			if (c_stf) begin
				n_crc = (crc_q >> 1) ^ ((crc_q[0] != c_sh[0]) ? hfbs_pkg::CRC_POLY : 16'h0000);
			end else if (c_seg == SEG_FLAG) begin
				n_crc = hfbs_pkg::CRC_INIT;
			end
			n_ones = c_sh[0] ? ones_inc : 3'd0;
			stuff  = c_stf && c_sh[0] && (ones_inc == hfbs_pkg::STUFF_RUN);
			if (stuff) begin
				n_ones = '0;
				n_pend = 1'b1;
				n_fin  = (c_cnt == 3'd0);
			end
			seg_end = (c_cnt == 3'd0) && !stuff;
		end

		if (seg_end) begin
			case (c_seg)
				SEG_FCS_LO: begin
					n_sh  = c_hi;
					n_cnt = 3'd7;
					n_stf = 1'b1;
					n_seg = SEG_FCS_HI;
				end
				SEG_FCS_HI: begin
					n_sh  = hfbs_pkg::FLAG_BYTE;
					n_cnt = 3'd7;
					n_stf = 1'b0;
					n_seg = SEG_FLAG;
				end
				default: begin
					n_busy = 1'b0;
					last_o = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			crc_q     <= hfbs_pkg::CRC_INIT;
			ones_q    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (go) begin
				busy_q    <= n_busy;
				crc_q     <= n_crc;
				ones_q    <= n_ones;
				res_vld_q <= 1'b1;
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sh_q           <= n_sh;
			cnt_q          <= n_cnt;
			stf_q          <= n_stf;
			pend_q         <= n_pend;
			fin_q          <= n_fin;
			seg_q          <= n_seg;
			hi_q           <= c_hi;
			res_q.line_bit <= bit_o;
			res_q.last_bit <= last_o;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

// ----- src/hfbs_checker.sv -----
module hfbs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input hfbs_pkg::in_item_t  item,
	input logic                result_valid,
	input logic                result_stall,
	input hfbs_pkg::out_item_t result
);

	// A stalled result transaction keeps its bits.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A stalled input transaction stays offered and keeps its fields.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("input changed while stalled");

	// Within one item the bits leave without gaps.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.last_bit |=> result_valid)
		else $error("gap inside the bits of one item");

	// Reset leaves no result pending.
	a_reset: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	// A full queue with an idle output register starts a transaction on the next cycle.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall && !result_valid && !result_stall |=> !item_stall || result_valid)
		else $error("input stalled with idle output");

endmodule

bind hdlc_frame_bit_serializer_core hfbs_checker u_hfbs_checker (.*);
